// ===== rtl/dram_frfcfs_scheduler_top_assert.svh =====
// assertion macros for the fr-fcfs scheduler checker
`ifndef DRAM_FRFCFS_SCHEDULER_TOP_ASSERT_SVH
`define DRAM_FRFCFS_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define DFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== rtl/dfs_pkg.sv =====
// shared types, constants and window shapes of the fr-fcfs scheduler
package dfs_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int INFLIGHT_DEPTH = 8;
    localparam int NUM_BANKS      = 8;
    localparam int WINDOW_LEN     = 350;
    localparam int QIDX_W         = $clog2(QUEUE_DEPTH);
    localparam int FIDX_W         = $clog2(INFLIGHT_DEPTH);
    localparam int BANK_W         = $clog2(NUM_BANKS);
    localparam int CNT_W          = $clog2(WINDOW_LEN + 1);
    localparam int ROW_W          = 16;
    localparam int TAG_W          = 4;
    localparam int STAMP_W        = 32;
    localparam int BANK_LSB       = 5;
    localparam int ROW_LSB        = 16;
    localparam int DATA_LEN       = 50;
    localparam int CMD_LEN        = 4;
    localparam int CMD_PITCH      = 100;

    localparam logic [1:0] KIND_CLOSED = 2'd0;
    localparam logic [1:0] KIND_HIT    = 2'd1;
    localparam logic [1:0] KIND_MISS   = 2'd2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef struct packed {
        logic               is_tick;
        logic [TAG_W-1:0]   tag;
        logic [BANK_W-1:0]  bank;
        logic [ROW_W-1:0]   row;
        logic               src;
    } cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BANK_W-1:0]  bank;
        logic [ROW_W-1:0]   row;
        logic [STAMP_W-1:0] stamp;
        logic               src;
    } pend_t;

    typedef struct packed {
        logic               accepted;
        logic               issued_valid;
        logic [TAG_W-1:0]   issued_tag;
        logic [1:0]         issued_kind;
        logic               done_valid;
        logic [TAG_W-1:0]   done_tag;
    } rsp_t;

    function automatic logic [CNT_W-1:0] data_start(input logic [1:0] kind);
        case (kind)
            KIND_HIT:    data_start = CNT_W'(100);
            KIND_CLOSED: data_start = CNT_W'(200);
            default:     data_start = CNT_W'(300);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] bank_end(input logic [1:0] kind);
        bank_end = data_start(kind);
    endfunction

    function automatic logic [1:0] cmd_groups(input logic [1:0] kind);
        case (kind)
            KIND_HIT:    cmd_groups = 2'd1;
            KIND_CLOSED: cmd_groups = 2'd2;
            default:     cmd_groups = 2'd3;
        endcase
    endfunction

    function automatic logic [WINDOW_LEN-1:0] data_mask(input logic [1:0] kind);
        logic [WINDOW_LEN-1:0] m;
        m = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (CNT_W'(i) >= data_start(kind) &&
                CNT_W'(i) < data_start(kind) + CNT_W'(DATA_LEN))
            begin
                m[i] = 1'b1;
            end
        end
        data_mask = m;
    endfunction

    function automatic logic [WINDOW_LEN-1:0] cmd_mask(input logic [1:0] kind);
        logic [WINDOW_LEN-1:0] m;
        m = '0;
        for (int g = 0; g < 3; g++)
        begin
            for (int j = 0; j < CMD_LEN; j++)
            begin
                if (2'(g) < cmd_groups(kind))
                begin
                    m[g * CMD_PITCH + j] = 1'b1;
                end
            end
        end
        cmd_mask = m;
    endfunction

endpackage

// ===== rtl/dfs_req_if.sv =====
// request channel: valid, ready and one command item
interface dfs_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] address;
    logic [3:0]  request_tag;
    logic        is_instruction;

    modport source (output valid, opcode, address, request_tag, is_instruction, input ready);
    modport sink (input valid, opcode, address, request_tag, is_instruction, output ready);
endinterface

// ===== rtl/dfs_rsp_if.sv =====
// result channel: valid, ready and one result item
interface dfs_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       issued_valid;
    logic [3:0] issued_tag;
    logic [1:0] issued_kind;
    logic       done_valid;
    logic [3:0] done_tag;

    modport source (output valid, accepted, issued_valid, issued_tag, issued_kind,
                    done_valid, done_tag, input ready);
    modport sink (input valid, accepted, issued_valid, issued_tag, issued_kind,
                  done_valid, done_tag, output ready);
endinterface

// ===== rtl/dram_frfcfs_scheduler_top.sv =====
// fr-fcfs dram scheduler: an enqueue passes the command queue and is answered from idle
// a tick is taken in idle, scans the 16 queue slots one per cycle, then commits
// throughput is bound by the back end, which works on one item at a time
// a two-entry command queue lets the front accept while the back end is busy
// asynchronous active-low reset empties every queue, closes all rows, frees all windows
module dram_frfcfs_scheduler_top (
    input  logic      clk,
    input  logic      rst_n,
    dfs_req_if.sink   req,
    dfs_rsp_if.source rsp
);
    import dfs_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    dfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    dfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );
endmodule

// ===== rtl/dfs_front.sv =====
// front end: accepts items, decodes bank and row, two-entry command queue
module dfs_front (
    input  logic          clk,
    input  logic          rst_n,
    dfs_req_if.sink       req,
    output logic          cmd_valid,
    output dfs_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import dfs_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       dec;

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        dec.is_tick = (req.opcode == OP_TICK);
        dec.tag     = req.request_tag;
        dec.bank    = req.address[BANK_LSB +: BANK_W];
        dec.row     = req.address[ROW_LSB +: ROW_W];
        dec.src     = req.is_instruction;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule

// ===== rtl/dfs_back.sv =====
// back end: pending queue, entry scan, window reservation and completion
module dfs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  dfs_pkg::cmd_t cmd,
    output logic          cmd_pop,
    dfs_rsp_if.source     rsp
);
    import dfs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [QUEUE_DEPTH-1:0]  pv_reg, pv_next;
    pend_t                   pend_reg [QUEUE_DEPTH];
    logic [INFLIGHT_DEPTH-1:0] fv_reg, fv_next;
    logic [TAG_W-1:0]        ft_reg [INFLIGHT_DEPTH];
    logic [TAG_W-1:0]        ft_next [INFLIGHT_DEPTH];
    logic [CNT_W-1:0]        fc_reg [INFLIGHT_DEPTH];
    logic [CNT_W-1:0]        fc_next [INFLIGHT_DEPTH];
    logic [STAMP_W-1:0]      cycle_reg, cycle_next;
    logic [ROW_W-1:0]        open_row_reg [NUM_BANKS];
    logic [NUM_BANKS-1:0]    row_open_reg, row_open_next;
    logic [WINDOW_LEN-1:0]   data_win_reg, data_win_next;
    logic [WINDOW_LEN-1:0]   cmd_win_reg, cmd_win_next;
    logic [CNT_W-1:0]        bank_cnt_reg [NUM_BANKS];
    logic [CNT_W-1:0]        bank_cnt_next [NUM_BANKS];
    logic [QIDX_W-1:0]       scan_reg, scan_next;
    logic                    best_v_reg, best_v_next;
    logic [QIDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [1:0]              best_kind_reg, best_kind_next;
    logic                    best_hit_reg, best_hit_next;
    logic [STAMP_W-1:0]      best_age_reg, best_age_next;
    logic                    best_src_reg, best_src_next;
    logic                    slot_ok_reg, slot_ok_next;
    logic [FIDX_W-1:0]       slot_reg, slot_next;
    logic                    out_v_reg, out_v_next;
    rsp_t                    out_reg, out_next;

    logic                    out_free;
    logic                    enq_we;
    logic [QIDX_W-1:0]       enq_idx;
    logic                    commit;
    logic [2:0]              bus_ok;
    pend_t                   cur;
    logic [1:0]              cur_kind;
    logic                    cur_fit, cur_hit, better;
    logic [STAMP_W-1:0]      cur_age;
    pend_t                   best;
    logic [WINDOW_LEN-1:0]   data_res, cmd_res;
    logic [CNT_W-1:0]        bc;
    logic [INFLIGHT_DEPTH-1:0] fv_tmp;
    logic [CNT_W-1:0]        fc_tmp [INFLIGHT_DEPTH];
    logic                    found;

    assign out_free     = !out_v_reg || rsp.ready;
    assign rsp.valid        = out_v_reg;
    assign rsp.accepted     = out_reg.accepted;
    assign rsp.issued_valid = out_reg.issued_valid;
    assign rsp.issued_tag   = out_reg.issued_tag;
    assign rsp.issued_kind  = out_reg.issued_kind;
    assign rsp.done_valid   = out_reg.done_valid;
    assign rsp.done_tag     = out_reg.done_tag;

    // bus availability per kind
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            bus_ok[k] = ((data_win_reg & data_mask(2'(k))) == '0) &&
                        ((cmd_win_reg & cmd_mask(2'(k))) == '0);
        end
    end

    // classification of the scanned entry
    always_comb
    begin
        cur = pend_reg[scan_reg];
        if (!row_open_reg[cur.bank])
        begin
            cur_kind = KIND_CLOSED;
        end
        else if (open_row_reg[cur.bank] == cur.row)
        begin
            cur_kind = KIND_HIT;
        end
        else
        begin
            cur_kind = KIND_MISS;
        end
        cur_hit = (cur_kind == KIND_HIT);
        cur_fit = pv_reg[scan_reg] && slot_ok_reg && bus_ok[cur_kind] &&
                  (bank_cnt_reg[cur.bank] == '0);
        cur_age = cycle_reg - cur.stamp;
        if (!best_v_reg)
        begin
            better = 1'b1;
        end
        else if (cur_hit != best_hit_reg)
        begin
            better = cur_hit;
        end
        else if (cur_age != best_age_reg)
        begin
            better = cur_age > best_age_reg;
        end
        else
        begin
            better = !cur.src && best_src_reg;
        end
    end

    always_comb
    begin
        enq_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!pv_reg[i])
            begin
                enq_idx = QIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pv_next        = pv_reg;
        fv_next        = fv_reg;
        ft_next        = ft_reg;
        fc_next        = fc_reg;
        cycle_next     = cycle_reg;
        row_open_next  = row_open_reg;
        data_win_next  = data_win_reg;
        cmd_win_next   = cmd_win_reg;
        bank_cnt_next  = bank_cnt_reg;
        scan_next      = scan_reg;
        best_v_next    = best_v_reg;
        best_idx_next  = best_idx_reg;
        best_kind_next = best_kind_reg;
        best_hit_next  = best_hit_reg;
        best_age_next  = best_age_reg;
        best_src_next  = best_src_reg;
        slot_ok_next   = slot_ok_reg;
        slot_next      = slot_reg;
        out_v_next     = out_v_reg && !rsp.ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        enq_we         = 1'b0;
        commit         = 1'b0;
        best           = pend_reg[best_idx_reg];
        data_res       = '0;
        cmd_res        = '0;
        bc             = '0;
        fv_tmp         = '0;
        fc_tmp         = fc_reg;
        found          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (!cmd.is_tick)
                    begin
                        out_next   = '0;
                        out_v_next = 1'b1;
                        if (!(&pv_reg))
                        begin
                            enq_we            = 1'b1;
                            pv_next[enq_idx]  = 1'b1;
                            out_next.accepted = 1'b1;
                        end
                    end
                    else
                    begin
                        scan_next    = '0;
                        best_v_next  = 1'b0;
                        slot_ok_next = !(&fv_reg);
                        slot_next    = '0;
                        for (int i = INFLIGHT_DEPTH - 1; i >= 0; i--)
                        begin
                            if (!fv_reg[i])
                            begin
                                slot_next = FIDX_W'(i);
                            end
                        end
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cur_fit && better)
                begin
                    best_v_next    = 1'b1;
                    best_idx_next  = scan_reg;
                    best_kind_next = cur_kind;
                    best_hit_next  = cur_hit;
                    best_age_next  = cur_age;
                    best_src_next  = cur.src;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == QIDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    out_next   = '0;
                    out_v_next = 1'b1;
                    data_res   = data_win_reg;
                    cmd_res    = cmd_win_reg;
                    fv_tmp     = fv_reg;
                    if (best_v_reg)
                    begin
                        data_res = data_res | data_mask(best_kind_reg);
                        cmd_res  = cmd_res | cmd_mask(best_kind_reg);
                        pv_next[best_idx_reg]     = 1'b0;
                        row_open_next[best.bank]  = 1'b1;
                        fv_tmp[slot_reg]          = 1'b1;
                        ft_next[slot_reg]         = best.tag;
                        fc_tmp[slot_reg]          = data_start(best_kind_reg) +
                                                    CNT_W'(DATA_LEN);
                        out_next.issued_valid     = 1'b1;
                        out_next.issued_tag       = best.tag;
                        out_next.issued_kind      = best_kind_reg;
                    end
                    data_win_next = {1'b0, data_res[WINDOW_LEN-1:1]};
                    cmd_win_next  = {1'b0, cmd_res[WINDOW_LEN-1:1]};
                    for (int j = 0; j < NUM_BANKS; j++)
                    begin
                        bc = (best_v_reg && best.bank == BANK_W'(j)) ?
                             bank_end(best_kind_reg) : bank_cnt_reg[j];
                        bank_cnt_next[j] = (bc != '0) ? bc - 1'b1 : bc;
                    end
                    for (int i = 0; i < INFLIGHT_DEPTH; i++)
                    begin
                        if (fv_tmp[i] && fc_tmp[i] != '0)
                        begin
                            fc_tmp[i] = fc_tmp[i] - 1'b1;
                        end
                    end
                    fv_next = fv_tmp;
                    for (int i = 0; i < INFLIGHT_DEPTH; i++)
                    begin
                        if (!found && fv_tmp[i] && fc_tmp[i] == '0)
                        begin
                            found               = 1'b1;
                            fv_next[i]          = 1'b0;
                            out_next.done_valid = 1'b1;
                            out_next.done_tag   = ft_next[i];
                        end
                    end
                    fc_next    = fc_tmp;
                    cycle_next = cycle_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pv_reg       <= '0;
            fv_reg       <= '0;
            cycle_reg    <= '0;
            row_open_reg <= '0;
            data_win_reg <= '0;
            cmd_win_reg  <= '0;
            for (int j = 0; j < NUM_BANKS; j++)
            begin
                bank_cnt_reg[j] <= '0;
            end
            best_v_reg   <= 1'b0;
            slot_ok_reg  <= 1'b0;
            scan_reg     <= '0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pv_reg       <= pv_next;
            fv_reg       <= fv_next;
            cycle_reg    <= cycle_next;
            row_open_reg <= row_open_next;
            data_win_reg <= data_win_next;
            cmd_win_reg  <= cmd_win_next;
            bank_cnt_reg <= bank_cnt_next;
            best_v_reg   <= best_v_next;
            slot_ok_reg  <= slot_ok_next;
            scan_reg     <= scan_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ft_reg        <= ft_next;
        fc_reg        <= fc_next;
        best_idx_reg  <= best_idx_next;
        best_kind_reg <= best_kind_next;
        best_hit_reg  <= best_hit_next;
        best_age_reg  <= best_age_next;
        best_src_reg  <= best_src_next;
        slot_reg      <= slot_next;
        out_reg       <= out_next;
        if (enq_we)
        begin
            pend_reg[enq_idx] <= '{tag: cmd.tag, bank: cmd.bank, row: cmd.row,
                                   stamp: cycle_reg, src: cmd.src};
        end
        if (commit && best_v_reg)
        begin
            open_row_reg[best.bank] <= best.row;
        end
    end
endmodule

// ===== rtl/dfs_checker.sv =====
// port-level checker of the fr-fcfs scheduler and its bind
`include "dram_frfcfs_scheduler_top_assert.svh"

module dfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       accepted,
    input logic       issued_valid,
    input logic [3:0] issued_tag,
    input logic [1:0] issued_kind,
    input logic       done_valid,
    input logic [3:0] done_tag
);
    `DFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `DFS_ASSERT_SAME(a_enq_only, out_valid && accepted, !issued_valid && !done_valid)
    `DFS_ASSERT_SAME(a_idle_issue, out_valid && !issued_valid, issued_tag == 4'd0 && issued_kind == 2'd0)
    `DFS_ASSERT_SAME(a_idle_done, out_valid && !done_valid, done_tag == 4'd0 && issued_kind != 2'd3)
endmodule

bind dram_frfcfs_scheduler_top dfs_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .accepted     (rsp.accepted),
    .issued_valid (rsp.issued_valid),
    .issued_tag   (rsp.issued_tag),
    .issued_kind  (rsp.issued_kind),
    .done_valid   (rsp.done_valid),
    .done_tag     (rsp.done_tag)
);

// ===== tb/dfs_tb_pkg.sv =====
// item and result types shared by the scheduler testbench
package dfs_tb_pkg;

    import dfs_pkg::*;

    typedef struct {
        logic        opcode;
        logic [31:0] address;
        logic [3:0]  request_tag;
        logic        is_instruction;
    } sched_cmd_t;

    typedef struct {
        logic       accepted;
        logic       issued_valid;
        logic [3:0] issued_tag;
        logic [1:0] issued_kind;
        logic       done_valid;
        logic [3:0] done_tag;
    } sched_res_t;

endpackage

// ===== tb/dram_frfcfs_scheduler_top_test.sv =====
// testbench of the fr-fcfs dram scheduler: queued stimulus, behavioral predictor, field checks
module dram_frfcfs_scheduler_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dfs_pkg::*;
    import dfs_tb_pkg::*;

    logic clk;
    logic rst_n;

    dfs_req_if req ();
    dfs_rsp_if rsp ();

    dram_frfcfs_scheduler_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor state
    logic              pq_valid [QUEUE_DEPTH];
    logic [3:0]        pq_tag [QUEUE_DEPTH];
    logic [2:0]        pq_bank [QUEUE_DEPTH];
    logic [15:0]       pq_row [QUEUE_DEPTH];
    logic [31:0]       pq_stamp [QUEUE_DEPTH];
    logic              pq_src [QUEUE_DEPTH];
    logic              fl_valid [INFLIGHT_DEPTH];
    logic [3:0]        fl_tag [INFLIGHT_DEPTH];
    int                fl_count [INFLIGHT_DEPTH];
    logic [31:0]       now_cycle;
    logic [15:0]       bank_row [NUM_BANKS];
    logic              bank_open [NUM_BANKS];
    logic [WINDOW_LEN-1:0] data_busy;
    logic [WINDOW_LEN-1:0] cmd_busy;
    logic [7:0]        bank_busy [WINDOW_LEN];

    sched_cmd_t  pending_items[$];
    sched_res_t  expected_results[$];
    int          failures;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_send;

    function automatic int data_begin(input logic [1:0] kind);
        return kind == KIND_HIT ? 100 : (kind == KIND_CLOSED ? 200 : 300);
    endfunction

    function automatic logic slot_needs_data(input logic [1:0] kind, input int i);
        return i >= data_begin(kind) && i < data_begin(kind) + 50;
    endfunction

    function automatic logic slot_needs_cmd(input logic [1:0] kind, input int i);
        int groups;
        groups = kind == KIND_HIT ? 1 : (kind == KIND_CLOSED ? 2 : 3);
        return (i % 100) < 4 && (i / 100) < groups;
    endfunction

    function automatic logic windows_free(input logic [1:0] kind, input logic [2:0] b);
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (data_busy[i] && slot_needs_data(kind, i))
                return 1'b0;
            if (cmd_busy[i] && slot_needs_cmd(kind, i))
                return 1'b0;
            if (bank_busy[i][b] && i < data_begin(kind))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_schedule();
        foreach (pq_valid[i])
            pq_valid[i] = 1'b0;
        foreach (fl_valid[i])
            fl_valid[i] = 1'b0;
        foreach (bank_open[i])
        begin
            bank_open[i] = 1'b0;
            bank_row[i] = '0;
        end
        foreach (bank_busy[i])
            bank_busy[i] = '0;
        data_busy = '0;
        cmd_busy = '0;
        now_cycle = '0;
    endtask

    function automatic sched_res_t schedule_step(input sched_cmd_t c);
        sched_res_t r;
        int best;
        int slot;
        logic [1:0] best_kind;
        logic [1:0] k;
        logic best_hit;
        logic hit;
        logic better;
        logic [31:0] best_age;
        logic [31:0] age;
        r = '{default: '0};
        if (c.opcode == OP_ENQUEUE)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!pq_valid[i])
                begin
                    pq_valid[i] = 1'b1;
                    pq_tag[i] = c.request_tag;
                    pq_bank[i] = c.address[7:5];
                    pq_row[i] = c.address[31:16];
                    pq_stamp[i] = now_cycle;
                    pq_src[i] = c.is_instruction;
                    r.accepted = 1'b1;
                    break;
                end
            end
            return r;
        end
        best = -1;
        slot = -1;
        best_kind = KIND_CLOSED;
        best_hit = 1'b0;
        best_age = '0;
        for (int i = 0; i < INFLIGHT_DEPTH; i++)
        begin
            if (!fl_valid[i])
            begin
                slot = i;
                break;
            end
        end
        if (slot >= 0)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!pq_valid[i])
                    continue;
                if (!bank_open[pq_bank[i]])
                    k = KIND_CLOSED;
                else
                    k = bank_row[pq_bank[i]] == pq_row[i] ? KIND_HIT : KIND_MISS;
                if (!windows_free(k, pq_bank[i]))
                    continue;
                hit = k == KIND_HIT;
                age = now_cycle - pq_stamp[i];
                if (best < 0)
                    better = 1'b1;
                else if (hit != best_hit)
                    better = hit;
                else if (age != best_age)
                    better = age > best_age;
                else
                    better = !pq_src[i] && pq_src[best];
                if (better)
                begin
                    best = i;
                    best_kind = k;
                    best_hit = hit;
                    best_age = age;
                end
            end
        end
        if (best >= 0)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                if (slot_needs_data(best_kind, i))
                    data_busy[i] = 1'b1;
                if (slot_needs_cmd(best_kind, i))
                    cmd_busy[i] = 1'b1;
                if (i < data_begin(best_kind))
                    bank_busy[i][pq_bank[best]] = 1'b1;
            end
            fl_valid[slot] = 1'b1;
            fl_tag[slot] = pq_tag[best];
            fl_count[slot] = data_begin(best_kind) + 50;
            bank_row[pq_bank[best]] = pq_row[best];
            bank_open[pq_bank[best]] = 1'b1;
            pq_valid[best] = 1'b0;
            r.issued_valid = 1'b1;
            r.issued_tag = pq_tag[best];
            r.issued_kind = best_kind;
        end
        data_busy = data_busy >> 1;
        cmd_busy = cmd_busy >> 1;
        for (int i = 0; i < WINDOW_LEN - 1; i++)
            bank_busy[i] = bank_busy[i + 1];
        bank_busy[WINDOW_LEN - 1] = '0;
        for (int i = 0; i < INFLIGHT_DEPTH; i++)
            if (fl_valid[i] && fl_count[i] > 0)
                fl_count[i]--;
        for (int i = 0; i < INFLIGHT_DEPTH; i++)
        begin
            if (fl_valid[i] && fl_count[i] == 0)
            begin
                r.done_valid = 1'b1;
                r.done_tag = fl_tag[i];
                fl_valid[i] = 1'b0;
                break;
            end
        end
        now_cycle++;
        return r;
    endfunction

    function automatic sched_cmd_t make_cmd(input logic op, input logic [31:0] a,
                                            input logic [3:0] t, input logic s);
        sched_cmd_t c;
        c.opcode = op;
        c.address = a;
        c.request_tag = t;
        c.is_instruction = s;
        return c;
    endfunction

    function automatic logic [31:0] rand_addr();
        logic [31:0] a;
        a = $urandom;
        // narrow rows to get plenty of row hits
        if ($urandom_range(0, 3) != 0)
            a[31:16] = 16'($urandom_range(0, 3));
        return a;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.opcode <= OP_TICK;
            req.address <= '0;
            req.request_tag <= '0;
            req.is_instruction <= 1'b0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                expected_results.push_back(schedule_step(pending_items.pop_front()));
            if (pending_items.size() > 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                req.valid <= 1'b1;
                req.opcode <= pending_items[0].opcode;
                req.address <= pending_items[0].address;
                req.request_tag <= pending_items[0].request_tag;
                req.is_instruction <= pending_items[0].is_instruction;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    failures++;
                end
                else
                begin
                    sched_res_t e;
                    e = expected_results.pop_front();
                    if (rsp.accepted !== e.accepted)
                    begin
                        $error("accepted expected %0d got %0d", e.accepted, rsp.accepted);
                        failures++;
                    end
                    if (rsp.issued_valid !== e.issued_valid)
                    begin
                        $error("issued_valid expected %0d got %0d", e.issued_valid,
                               rsp.issued_valid);
                        failures++;
                    end
                    if (rsp.issued_tag !== e.issued_tag)
                    begin
                        $error("issued_tag expected %0d got %0d", e.issued_tag, rsp.issued_tag);
                        failures++;
                    end
                    if (rsp.issued_kind !== e.issued_kind)
                    begin
                        $error("issued_kind expected %0d got %0d", e.issued_kind,
                               rsp.issued_kind);
                        failures++;
                    end
                    if (rsp.done_valid !== e.done_valid)
                    begin
                        $error("done_valid expected %0d got %0d", e.done_valid, rsp.done_valid);
                        failures++;
                    end
                    if (rsp.done_tag !== e.done_tag)
                    begin
                        $error("done_tag expected %0d got %0d", e.done_tag, rsp.done_tag);
                        failures++;
                    end
                end
            end
            rsp.ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        int n;
        phase_idle = '{0, 73, 0, 9};
        phase_stall = '{0, 0, 73, 9};
        failures = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        clear_schedule();
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b0;
        #1 rst_n = 1'b1;

        // directed: fill the queue past full, extremes of fields, ticks before and after the fill
        pending_items.push_back(make_cmd(OP_TICK, 32'hFFFF_FFFF, 4'hF, 1'b1));
        for (int i = 0; i < 17; i++)
            pending_items.push_back(make_cmd(OP_ENQUEUE,
                i == 0 ? 32'h0 : (i == 1 ? 32'hFFFF_FFFF : {16'(i % 3), 8'h0, 3'(i), 5'h1F}),
                4'(i), i[0]));
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_cmd(OP_TICK, '0, '0, 1'b0));
        drain();

        // sender held with five random ticks queued, then released and drained
        hold_send = 1'b1;
        for (int i = 0; i < 5; i++)
            pending_items.push_back(make_cmd(OP_TICK, $urandom, 4'($urandom), 1'($urandom)));
        repeat (50)
            @(posedge clk);
        hold_send = 1'b0;
        drain();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            n = 0;
            while (n < 180)
            begin
                // bursts of enqueues then runs of ticks so requests issue and complete
                int burst;
                burst = $urandom_range(1, 6);
                for (int j = 0; j < burst; j++)
                    pending_items.push_back(make_cmd(OP_ENQUEUE, rand_addr(), 4'($urandom),
                                                     1'($urandom)));
                n += burst;
                burst = $urandom_range(0, 3) == 0 ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
                for (int j = 0; j < burst; j++)
                    pending_items.push_back(make_cmd(OP_TICK, $urandom, 4'($urandom),
                                                     1'($urandom)));
                n += burst;
            end
            drain();
        end
        repeat (60)
            @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
